// File: rtl/tx_buffer_pool_queue_unit_macros.svh
// Assertion macros shared by the transmit buffer pool modules
`ifndef TX_BUFFER_POOL_QUEUE_UNIT_MACROS_SVH
`define TX_BUFFER_POOL_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication on clk, switched off while rst_n is low
`define TBPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, switched off while rst_n is low
`define TBPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tbpq_pkg.sv
// Shared constants, command codes and control struct for the transmit buffer pool
package tbpq_pkg;

    // Default pool geometry
    localparam int NUM_BUFFERS_DEF  = 8;
    localparam int BUFFER_BYTES_DEF = 64;

    // Fixed port widths
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int RBUF_W    = 3;
    localparam int ROFS_W    = 6;
    localparam int SBUF_W    = 3;
    localparam int SLEN_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int DROP_W    = 3;
    localparam int QCOUNT_W  = 4;
    localparam int LANE_W    = 2;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WORD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRIM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_XFER  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // Per-cycle operation from controller to datapath
    typedef struct packed {
        logic              load;        // latch a new request
        logic              put;         // append the byte in lane
        logic              trim;        // skip leading zero lanes
        logic [LANE_W-1:0] lane;        // byte lane, 3 is most significant
        logic              flush;       // queue the fill buffer
        logic              xfer;        // transfer of queue head finished
        logic              rd_issue;    // drive read address to the store
        logic              rd_capture;  // capture read data
    } ctl_t;

endpackage

// File: rtl/tx_buffer_pool_queue_unit.sv
// Top level of the transmit buffer pool with send queue
//
// A request is taken when start is high and busy is low; its result is shown
// for one cycle with done high and cannot be held off, and the next request
// may be taken in that same cycle. Word and trimmed number appends step all
// four byte lanes through the single-port byte store one per cycle, leading
// zero lanes included. A read waits on the registered read of the byte store.
// No clearing pass is needed after reset. The result fields hold their value
// after the done strobe.
module tx_buffer_pool_queue_unit #(
    parameter int NUM_BUFFERS  = tbpq_pkg::NUM_BUFFERS_DEF,
    parameter int BUFFER_BYTES = tbpq_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [tbpq_pkg::CMD_W-1:0]    command,
    input  logic [tbpq_pkg::VALUE_W-1:0]  value,
    input  logic [tbpq_pkg::RBUF_W-1:0]   read_buffer,
    input  logic [tbpq_pkg::ROFS_W-1:0]   read_offset,
    output logic                          start_transfer,
    output logic [tbpq_pkg::SBUF_W-1:0]   start_buffer,
    output logic [tbpq_pkg::SLEN_W-1:0]   start_length,
    output logic [tbpq_pkg::BYTE_W-1:0]   read_data,
    output logic [tbpq_pkg::DROP_W-1:0]   dropped_bytes,
    output logic [tbpq_pkg::QCOUNT_W-1:0] queued_count
);

    import tbpq_pkg::*;

    ctl_t ctl;

    // Sequencer
    tbpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .ctl     (ctl)
    );

    // Pool datapath
    tbpq_dpath #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .value          (value),
        .read_buffer    (read_buffer),
        .read_offset    (read_offset),
        .start_transfer (start_transfer),
        .start_buffer   (start_buffer),
        .start_length   (start_length),
        .read_data      (read_data),
        .dropped_bytes  (dropped_bytes),
        .queued_count   (queued_count)
    );

endmodule

// File: rtl/tbpq_ram.sv
// Generic single-port RAM with registered read
module tbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tbpq_ctrl.sv
// Request sequencer: steps byte lanes and memory read for each command
`include "tx_buffer_pool_queue_unit_macros.svh"

module tbpq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [tbpq_pkg::CMD_W-1:0] command,
    output logic                   busy,
    output logic                   done,
    output tbpq_pkg::ctl_t         ctl
);

    import tbpq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WORK   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              done_reg, done_next;

    // Next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        lane_next  = lane_reg;
        done_next  = 1'b0;
        ctl        = '0;
        ctl.lane   = lane_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    cmd_next   = command;
                    lane_next  = (command == CMD_WORD || command == CMD_TRIM) ?
                                 LANE_W'(3) : LANE_W'(0);
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                unique case (cmd_reg)
                    CMD_BYTE, CMD_WORD, CMD_TRIM:
                    begin
                        ctl.put  = 1'b1;
                        ctl.trim = (cmd_reg == CMD_TRIM);
                    end
                    CMD_FLUSH: ctl.flush    = 1'b1;
                    CMD_XFER:  ctl.xfer     = 1'b1;
                    CMD_READ:  ctl.rd_issue = 1'b1;
                    default:   ;
                endcase
                // Lanes run from most to least significant
                priority if (cmd_reg == CMD_READ)
                begin
                    state_next = S_RDWAIT;
                end
                else if (lane_reg != '0)
                begin
                    lane_next = lane_reg - 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_RDWAIT:
            begin
                ctl.rd_capture = 1'b1;
                state_next     = S_IDLE;
                done_next      = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_BYTE;
            lane_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            lane_reg  <= lane_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `TBPQ_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result strobe while busy")
    `TBPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start")
    `TBPQ_ASSERT_NEXT(a_read_done, state_reg == S_RDWAIT, done_reg, "read gave no result")

endmodule

// File: rtl/tbpq_dpath.sv
// Buffer pool datapath: free marks, fill buffer, send queue and byte store
`include "tx_buffer_pool_queue_unit_macros.svh"

module tbpq_dpath #(
    parameter int NUM_BUFFERS  = tbpq_pkg::NUM_BUFFERS_DEF,
    parameter int BUFFER_BYTES = tbpq_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbpq_pkg::ctl_t                ctl,
    input  logic [tbpq_pkg::VALUE_W-1:0]  value,
    input  logic [tbpq_pkg::RBUF_W-1:0]   read_buffer,
    input  logic [tbpq_pkg::ROFS_W-1:0]   read_offset,
    output logic                          start_transfer,
    output logic [tbpq_pkg::SBUF_W-1:0]   start_buffer,
    output logic [tbpq_pkg::SLEN_W-1:0]   start_length,
    output logic [tbpq_pkg::BYTE_W-1:0]   read_data,
    output logic [tbpq_pkg::DROP_W-1:0]   dropped_bytes,
    output logic [tbpq_pkg::QCOUNT_W-1:0] queued_count
);

    import tbpq_pkg::*;

    localparam int BW = $clog2(NUM_BUFFERS);
    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int QW = $clog2(NUM_BUFFERS + 1);
    localparam int AW = $clog2(NUM_BUFFERS * BUFFER_BYTES);

    // Pool state
    logic [NUM_BUFFERS-1:0] free_mask_reg, free_mask_next;
    logic [BW-1:0]          fill_index_reg, fill_index_next;
    logic [LW-1:0]          fill_len_reg, fill_len_next;
    logic                   fill_valid_reg, fill_valid_next;
    logic [QW-1:0]          qcount_reg, qcount_next;
    logic [BW-1:0]          q_buf_reg [NUM_BUFFERS];
    logic [LW-1:0]          q_len_reg [NUM_BUFFERS];

    // Request and result registers
    logic [VALUE_W-1:0]     val_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic                   rd_ok_reg;
    logic                   sent_reg, sent_next;
    logic                   st_start_reg, st_start_next;
    logic [BW-1:0]          st_buf_reg, st_buf_next;
    logic [LW-1:0]          st_len_reg, st_len_next;
    logic [BYTE_W-1:0]      rdata_reg, rdata_next;
    logic [DROP_W-1:0]      dropped_reg, dropped_next;

    // Working signals
    logic [BYTE_W-1:0]      byte_sel;
    logic                   live;
    logic                   take_free;
    logic                   enqueue;
    logic                   dequeue;
    logic                   mem_we;
    logic [LW-1:0]          len_inc;
    logic [LW-1:0]          enq_len;
    logic [NUM_BUFFERS-1:0] low_free;
    logic [BW-1:0]          low_idx;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          mem_addr;
    logic [BYTE_W-1:0]      mem_q;

    // Lowest free buffer: isolate the lowest set bit, then encode it
    always_comb
    begin
        low_free = free_mask_reg & (~free_mask_reg + NUM_BUFFERS'(1));
        low_idx  = '0;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            if (low_free[i])
            begin
                low_idx = low_idx | BW'(i);
            end
        end
    end

    assign byte_sel = val_reg[{ctl.lane, 3'b000} +: BYTE_W] & BYTE_MASK;
    assign live     = ctl.put && (!ctl.trim || byte_sel != '0 || sent_reg || ctl.lane == '0);
    assign len_inc  = LW'(fill_len_reg + 1'b1);
    assign wr_addr  = AW'(fill_index_reg) * AW'(BUFFER_BYTES) + AW'(fill_len_reg);
    assign dequeue  = ctl.xfer && qcount_reg != '0;

    // One step of the pool update
    always_comb
    begin
        free_mask_next  = free_mask_reg;
        fill_index_next = fill_index_reg;
        fill_len_next   = fill_len_reg;
        fill_valid_next = fill_valid_reg;
        qcount_next     = qcount_reg;
        sent_next       = sent_reg;
        st_start_next   = st_start_reg;
        st_buf_next     = st_buf_reg;
        st_len_next     = st_len_reg;
        rdata_next      = rdata_reg;
        dropped_next    = dropped_reg;
        take_free       = 1'b0;
        enqueue         = 1'b0;
        mem_we          = 1'b0;

        if (ctl.load)
        begin
            sent_next     = 1'b0;
            st_start_next = 1'b0;
            st_buf_next   = '0;
            st_len_next   = '0;
            rdata_next    = '0;
            dropped_next  = '0;
        end

        // Byte append, drop when no fill buffer
        if (live)
        begin
            sent_next = 1'b1;
            if (!fill_valid_reg)
            begin
                dropped_next = dropped_reg + 1'b1;
                take_free    = 1'b1;
            end
            else
            begin
                mem_we        = 1'b1;
                fill_len_next = len_inc;
                if (len_inc == LW'(BUFFER_BYTES))
                begin
                    enqueue   = 1'b1;
                    take_free = 1'b1;
                end
            end
        end

        if (ctl.flush)
        begin
            enqueue   = fill_valid_reg;
            take_free = 1'b1;
        end

        enq_len = mem_we ? len_inc : fill_len_reg;

        // Queue the fill buffer; start it when the queue was empty
        if (enqueue)
        begin
            qcount_next = qcount_reg + 1'b1;
            if (qcount_reg == '0)
            begin
                st_start_next = 1'b1;
                st_buf_next   = fill_index_reg;
                st_len_next   = enq_len;
            end
        end

        // Next fill buffer from the free pool
        if (take_free)
        begin
            if (free_mask_reg != '0)
            begin
                free_mask_next  = free_mask_reg & ~low_free;
                fill_index_next = low_idx;
                fill_len_next   = '0;
                fill_valid_next = 1'b1;
            end
            else
            begin
                fill_valid_next = 1'b0;
            end
        end

        // Head finished: free it and start the next one waiting
        if (dequeue)
        begin
            free_mask_next = free_mask_reg | (NUM_BUFFERS'(1) << q_buf_reg[0]);
            qcount_next    = qcount_reg - 1'b1;
            if (qcount_reg > QW'(1))
            begin
                st_start_next = 1'b1;
                st_buf_next   = q_buf_reg[1];
                st_len_next   = q_len_reg[1];
            end
        end

        if (ctl.rd_capture)
        begin
            rdata_next = rd_ok_reg ? mem_q : '0;
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_mask_reg  <= {{(NUM_BUFFERS-1){1'b1}}, 1'b0};
            fill_index_reg <= '0;
            fill_len_reg   <= '0;
            fill_valid_reg <= 1'b1;
            qcount_reg     <= '0;
            sent_reg       <= 1'b0;
            st_start_reg   <= 1'b0;
            st_buf_reg     <= '0;
            st_len_reg     <= '0;
            rdata_reg      <= '0;
            dropped_reg    <= '0;
        end
        else
        begin
            free_mask_reg  <= free_mask_next;
            fill_index_reg <= fill_index_next;
            fill_len_reg   <= fill_len_next;
            fill_valid_reg <= fill_valid_next;
            qcount_reg     <= qcount_next;
            sent_reg       <= sent_next;
            st_start_reg   <= st_start_next;
            st_buf_reg     <= st_buf_next;
            st_len_reg     <= st_len_next;
            rdata_reg      <= rdata_next;
            dropped_reg    <= dropped_next;
        end
    end

    // Request payload and send queue entries
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            val_reg     <= value;
            rd_addr_reg <= AW'(read_buffer) * AW'(BUFFER_BYTES) + AW'(read_offset);
            rd_ok_reg   <= (32'(read_buffer) < NUM_BUFFERS) &&
                           (32'(read_offset) < BUFFER_BYTES);
        end
        if (enqueue)
        begin
            q_buf_reg[qcount_reg[BW-1:0]] <= fill_index_reg;
            q_len_reg[qcount_reg[BW-1:0]] <= enq_len;
        end
        else if (dequeue)
        begin
            for (int i = 0; i < NUM_BUFFERS - 1; i++)
            begin
                q_buf_reg[i] <= q_buf_reg[i+1];
                q_len_reg[i] <= q_len_reg[i+1];
            end
        end
    end

    // Byte store: write on append, read on a read request
    assign mem_addr = mem_we ? wr_addr : rd_addr_reg;

    tbpq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NUM_BUFFERS * BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (ctl.rd_issue),
        .addr  (mem_addr),
        .wdata (byte_sel),
        .rdata (mem_q)
    );

    assign start_transfer = st_start_reg;
    assign start_buffer   = SBUF_W'(st_buf_reg);
    assign start_length   = SLEN_W'(st_len_reg);
    assign read_data      = rdata_reg;
    assign dropped_bytes  = dropped_reg;
    assign queued_count   = QCOUNT_W'(qcount_reg);

    `TBPQ_ASSERT_NOW(a_fill_owned, fill_valid_reg, !free_mask_reg[fill_index_reg], "fill buffer marked free")
    `TBPQ_ASSERT_NOW(a_queue_room, ctl.flush && fill_valid_reg, qcount_reg < QW'(NUM_BUFFERS), "send queue overflow")
    `TBPQ_ASSERT_NEXT(a_head_freed, dequeue, free_mask_reg[$past(q_buf_reg[0])], "finished head not freed")

endmodule

// File: sim/tx_buffer_pool_queue_checker.sv
// Checker for the transmit buffer pool: predicts each request's result and compares it
module tx_buffer_pool_queue_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [tbpq_pkg::CMD_W-1:0]          command,
    input  logic [tbpq_pkg::VALUE_W-1:0]        value,
    input  logic [tbpq_pkg::RBUF_W-1:0]         read_buffer,
    input  logic [tbpq_pkg::ROFS_W-1:0]         read_offset,
    input  logic                                start_transfer,
    input  logic [tbpq_pkg::SBUF_W-1:0]         start_buffer,
    input  logic [tbpq_pkg::SLEN_W-1:0]         start_length,
    input  logic [tbpq_pkg::BYTE_W-1:0]         read_data,
    input  logic [tbpq_pkg::DROP_W-1:0]         dropped_bytes,
    input  logic [tbpq_pkg::QCOUNT_W-1:0]       queued_count,
    output logic [tbpq_pkg::NUM_BUFFERS_DEF*tbpq_pkg::BUFFER_BYTES_DEF-1:0] byte_written,
    output int                                  pending_results,
    output int                                  fail_count
);
    import tbpq_pkg::*;

    localparam int NB    = NUM_BUFFERS_DEF;
    localparam int BB    = BUFFER_BYTES_DEF;
    localparam int STORE = NB * BB;

    typedef struct packed {
        logic              start_transfer;
        logic [SBUF_W-1:0] start_buffer;
        logic [SLEN_W-1:0] start_length;
        logic [BYTE_W-1:0] read_data;
        logic [DROP_W-1:0] dropped_bytes;
        logic [QCOUNT_W-1:0] queued_count;
    } pool_result_t;

    // Mirror of the pool state
    logic [BYTE_W-1:0] byte_mem [STORE];
    logic [SLEN_W-1:0] fill_len [NB];
    logic [NB-1:0]     free_bits;
    logic [SBUF_W-1:0] send_q [NB];
    int                q_count;
    logic [SBUF_W-1:0] fill_buf;
    bit                fill_ok;

    // Per-request side results
    bit                xfer_start;
    logic [SBUF_W-1:0] xfer_buf;
    logic [SLEN_W-1:0] xfer_len;
    int                drop_cnt;

    pool_result_t awaited_results [$];

    function automatic void reset_pool();
        int i;
        for (i = 0; i < NB; i++)
        begin
            fill_len[i] = '0;
            send_q[i]   = '0;
        end
        free_bits    = '1;
        free_bits[0] = 1'b0;
        q_count      = 0;
        fill_buf     = '0;
        fill_ok      = 1'b1;
        byte_written = '0;
    endfunction

    // Lowest free buffer becomes the fill buffer, if there is one
    function automatic void claim_free_buffer();
        int i;
        fill_ok = 1'b0;
        for (i = 0; i < NB; i++)
        begin
            if (free_bits[i] && !fill_ok)
            begin
                free_bits[i] = 1'b0;
                fill_len[i]  = '0;
                fill_buf     = SBUF_W'(i);
                fill_ok      = 1'b1;
            end
        end
    endfunction

    function automatic void launch_head();
        xfer_start = 1'b1;
        xfer_buf   = send_q[0];
        xfer_len   = fill_len[send_q[0]];
    endfunction

    // Queue the fill buffer; a transfer starts when the queue was empty
    function automatic void queue_fill();
        if (fill_ok && q_count < NB)
        begin
            send_q[q_count] = fill_buf;
            q_count++;
            if (q_count == 1)
                launch_head();
        end
        claim_free_buffer();
    endfunction

    function automatic void append_byte(logic [BYTE_W-1:0] b);
        int len;
        int slot;
        if (!fill_ok)
        begin
            drop_cnt++;
            claim_free_buffer();
        end
        else
        begin
            len = int'(fill_len[fill_buf]);
            if (len < BB)
            begin
                slot               = int'(fill_buf) * BB + len;
                byte_mem[slot]     = b;
                byte_written[slot] = 1'b1;
                len++;
                fill_len[fill_buf] = SLEN_W'(len);
            end
            if (len >= BB)
                queue_fill();
        end
    endfunction

    // Head of queue done: free it and start the next one waiting
    function automatic void retire_head();
        int i;
        logic [SBUF_W-1:0] head;
        if (q_count != 0)
        begin
            head            = send_q[0];
            free_bits[head] = 1'b1;
            fill_len[head]  = '0;
            for (i = 1; i < NB; i++)
                send_q[i-1] = send_q[i];
            send_q[NB-1] = '0;
            q_count--;
            if (q_count > 0)
                launch_head();
        end
    endfunction

    function automatic pool_result_t predict_request(logic [CMD_W-1:0] cmd,
                                                     logic [VALUE_W-1:0] val,
                                                     logic [RBUF_W-1:0] rb,
                                                     logic [ROFS_W-1:0] ro);
        pool_result_t r;
        logic [BYTE_W-1:0] lane;
        bit sent;
        int i;
        r          = '0;
        xfer_start = 1'b0;
        xfer_buf   = '0;
        xfer_len   = '0;
        drop_cnt   = 0;
        case (cmd)
            CMD_BYTE:
                append_byte(val[7:0]);
            CMD_WORD:
                for (i = 3; i >= 0; i--)
                    append_byte(val[8*i +: 8]);
            CMD_TRIM:
            begin
                // leading zero bytes skipped, the last byte always goes in
                sent = 1'b0;
                for (i = 3; i >= 0; i--)
                begin
                    lane = val[8*i +: 8];
                    if (lane != '0 || sent || i == 0)
                    begin
                        sent = 1'b1;
                        append_byte(lane);
                    end
                end
            end
            CMD_FLUSH:
                queue_fill();
            CMD_XFER:
                retire_head();
            CMD_READ:
                // index and offset widths cover the pool exactly
                r.read_data = byte_mem[int'(rb) * BB + int'(ro)];
            default:
                ;
        endcase
        r.start_transfer = xfer_start;
        r.start_buffer   = xfer_buf;
        r.start_length   = xfer_len;
        r.dropped_bytes  = DROP_W'(drop_cnt);
        r.queued_count   = QCOUNT_W'(q_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result with the oldest request outstanding, then log new requests
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        if (!rst_n)
        begin
            reset_pool();
            awaited_results.delete();
            pending_results = 0;
            fail_count      = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("start_transfer", 32'(want.start_transfer),
                                32'(start_transfer));
                    check_field("start_buffer", 32'(want.start_buffer), 32'(start_buffer));
                    check_field("start_length", 32'(want.start_length), 32'(start_length));
                    check_field("read_data", 32'(want.read_data), 32'(read_data));
                    check_field("dropped_bytes", 32'(want.dropped_bytes),
                                32'(dropped_bytes));
                    check_field("queued_count", 32'(want.queued_count), 32'(queued_count));
                end
            end
            if (start && !busy)
                awaited_results.push_back(predict_request(command, value,
                                                          read_buffer, read_offset));
            pending_results = awaited_results.size();
        end
    end

endmodule

// File: sim/tb_tx_buffer_pool_queue_unit.sv
// Testbench top for the transmit buffer pool: clock, reset, request stimulus and verdict
module tb_tx_buffer_pool_queue_unit;
    import tbpq_pkg::*;

    localparam int STORE = NUM_BUFFERS_DEF * BUFFER_BYTES_DEF;
    localparam int BB    = BUFFER_BYTES_DEF;

    // Codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    logic [CMD_W-1:0]    command;
    logic [VALUE_W-1:0]  value;
    logic [RBUF_W-1:0]   read_buffer;
    logic [ROFS_W-1:0]   read_offset;
    logic                start_transfer;
    logic [SBUF_W-1:0]   start_buffer;
    logic [SLEN_W-1:0]   start_length;
    logic [BYTE_W-1:0]   read_data;
    logic [DROP_W-1:0]   dropped_bytes;
    logic [QCOUNT_W-1:0] queued_count;
    logic [STORE-1:0]    byte_written;
    int                  pending_results;
    int                  fail_count;
    int                  sender_idle_pct;

    tx_buffer_pool_queue_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .command        (command),
        .value          (value),
        .read_buffer    (read_buffer),
        .read_offset    (read_offset),
        .start_transfer (start_transfer),
        .start_buffer   (start_buffer),
        .start_length   (start_length),
        .read_data      (read_data),
        .dropped_bytes  (dropped_bytes),
        .queued_count   (queued_count)
    );

    tx_buffer_pool_queue_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .command         (command),
        .value           (value),
        .read_buffer     (read_buffer),
        .read_offset     (read_offset),
        .start_transfer  (start_transfer),
        .start_buffer    (start_buffer),
        .start_length    (start_length),
        .read_data       (read_data),
        .dropped_bytes   (dropped_bytes),
        .queued_count    (queued_count),
        .byte_written    (byte_written),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // Present one request from a falling edge and hold it until taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                                input logic [RBUF_W-1:0] rb, input logic [ROFS_W-1:0] ro);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        value       <= val;
        read_buffer <= rb;
        read_offset <= ro;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        int k;
        int r;
        int probe;
        int slot;
        int xfer_pct;
        int flush_pct;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] val;
        logic [RBUF_W-1:0]  rb;
        logic [ROFS_W-1:0]  ro;

        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_BYTE;
        value           = '0;
        read_buffer     = '0;
        read_offset     = '0;
        sender_idle_pct = 0;
        xfer_pct        = 8;
        flush_pct       = 4;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-queue completion, value extremes, reads, flushes down to an
        // exhausted pool, drops, and a drop that picks up the freed buffer
        send_request(CMD_XFER, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_BYTE, 32'hFFFF_FF00, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_BYTE, 32'h0000_00FF, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_WORD, 32'hFFFF_FFFF, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_WORD, 32'h0000_0000, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_TRIM, 32'h0000_0000, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_TRIM, 32'h0000_0001, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_TRIM, 32'h0012_0034, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_TRIM, 32'h8000_0000, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_READ, $urandom, 3'd0, 6'd0);
        send_request(CMD_READ, $urandom, 3'd0, 6'd18);
        send_request(CMD_SPARE_A, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_SPARE_B, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        // first flush starts a transfer, the rest queue empty buffers until none is free
        repeat (8) send_request(CMD_FLUSH, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_WORD, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_FLUSH, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_XFER, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));
        send_request(CMD_BYTE, $urandom, RBUF_W'($urandom), ROFS_W'($urandom));

        // Random: phases of sender idling, with the traffic mix changed every 60 requests
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: sender_idle_pct = 87;
                2: sender_idle_pct = 19;
                default: sender_idle_pct = 0;
            endcase
            for (n = 0; n < 250; n++)
            begin
                if (n % 60 == 0)
                begin
                    // steady filling, queue build-up to exhaustion, or draining
                    case ($urandom_range(2))
                        0:
                        begin
                            xfer_pct  = 8;
                            flush_pct = 4;
                        end
                        1:
                        begin
                            xfer_pct  = 1;
                            flush_pct = 12;
                        end
                        default:
                        begin
                            xfer_pct  = 45;
                            flush_pct = 6;
                        end
                    endcase
                end
                r   = $urandom_range(99);
                val = $urandom;
                rb  = RBUF_W'($urandom);
                ro  = ROFS_W'($urandom);
                if (r < xfer_pct)
                    cmd = CMD_XFER;
                else if (r < xfer_pct + flush_pct)
                    cmd = CMD_FLUSH;
                else if (r < xfer_pct + flush_pct + 10)
                begin
                    // read only bytes that have been written; append if none exist
                    cmd   = CMD_BYTE;
                    probe = $urandom_range(STORE - 1);
                    for (k = 0; k < STORE; k++)
                    begin
                        slot = (probe + k) % STORE;
                        if (cmd != CMD_READ && byte_written[slot])
                        begin
                            cmd = CMD_READ;
                            rb  = RBUF_W'(slot / BB);
                            ro  = ROFS_W'(slot % BB);
                        end
                    end
                end
                else if (r < xfer_pct + flush_pct + 12)
                    cmd = $urandom_range(1) ? CMD_SPARE_B : CMD_SPARE_A;
                else
                begin
                    case ($urandom_range(2))
                        0: cmd = CMD_BYTE;
                        1: cmd = CMD_WORD;
                        default:
                        begin
                            cmd = CMD_TRIM;
                            val = ($urandom_range(7) == 0) ? '0 : val >> (8 * $urandom_range(3));
                        end
                    endcase
                end
                send_request(cmd, val, rb, ro);
            end
        end

        // Drain and give the verdict
        start <= 1'b0;
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
